// ===== hdl/ale_pkg.sv =====
// shared types and constants for the array list engine
// no dependencies; used by ale_store and array_list_engine_unit
package ale_pkg;

	localparam int CAPACITY = 16;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int DATA_W   = 32;

	typedef enum logic [1:0] {
		OP_INS_POS  = 2'd0,
		OP_INS_SORT = 2'd1,
		OP_DELETE   = 2'd2,
		OP_LOCATE   = 2'd3
	} ale_op_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_BADPOS  = 2'd1,
		ST_FULL    = 2'd2,
		ST_MISSING = 2'd3
	} ale_status_t;

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_SCAN = 6'b000010,
		S_SHUP = 6'b000100,
		S_PUT  = 6'b001000,
		S_SHDN = 6'b010000,
		S_FIN  = 6'b100000
	} ale_state_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] addr;
		logic [DATA_W-1:0] data;
	} ale_wr_t;

endpackage

// ===== hdl/array_list_engine_unit.sv =====
// array list engine top level: ordered list of signed 32-bit entries with a shared walker
// one request in flight at a time; the walker steps one entry per cycle through the
// entry store (one read port, one write port)
// reset (arst_n low, asynchronous) empties the list and drops any pending result
// depends on ale_pkg and ale_store
module array_list_engine_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  operation,
	input  logic [31:0] value,
	input  logic [4:0]  position,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [3:0]  found_index,
	output logic [4:0]  element_total
);
	import ale_pkg::*;

	ale_state_t          state_q;
	ale_op_t             op_q;
	logic [DATA_W-1:0]   value_q;
	logic [CNT_W-1:0]    pos_q;
	logic [CNT_W-1:0]    cursor_q;
	logic                pend_q;
	logic [ADDR_W-1:0]   pend_addr_q;
	logic [CNT_W-1:0]    count_q;
	ale_status_t         res_status_q;
	logic [ADDR_W-1:0]   res_found_q;
	logic                hit_q;
	logic                out_valid_q;
	logic [1:0]          out_status_q;
	logic [3:0]          out_found_q;
	logic [4:0]          out_total_q;

	ale_wr_t             wr;
	logic [ADDR_W-1:0]   rd_addr;
	logic [DATA_W-1:0]   rd_data;
	logic [CNT_W-1:0]    cur_inc;
	logic [CNT_W-1:0]    cur_dec;
	logic [CNT_W-1:0]    pos_in;
	logic                full;
	logic                less_now;
	logic                match_now;

	ale_store u_store (
		.clk     (clk),
		.wr      (wr),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign cur_inc   = cursor_q + CNT_W'(1);
	assign cur_dec   = cursor_q - CNT_W'(1);
	assign pos_in    = CNT_W'(position);
	assign full      = (count_q == CNT_W'(CAPACITY));
	assign less_now  = pend_q && (op_q == OP_INS_SORT) &&
		($signed(value_q) < $signed(rd_data));
	assign match_now = pend_q && (op_q == OP_LOCATE) && (rd_data == value_q);

	// read address of the walker: one entry ahead of the cursor in the shift steps, else the cursor itself
	always_comb begin
		case (state_q)
			S_SHUP:  rd_addr = cur_dec[ADDR_W-1:0];
			S_SHDN:  rd_addr = cur_inc[ADDR_W-1:0];
			default: rd_addr = cursor_q[ADDR_W-1:0];
		endcase
	end

	always_comb begin
		wr = '0;
		case (state_q)
			S_SHUP, S_SHDN: begin
				wr.we   = pend_q;
				wr.addr = pend_addr_q;
				wr.data = rd_data;
			end
			S_PUT: begin
				wr.we   = 1'b1;
				wr.addr = pos_q[ADDR_W-1:0];
				wr.data = value_q;
			end
			default: wr = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			op_q         <= OP_INS_POS;
			value_q      <= '0;
			pos_q        <= '0;
			cursor_q     <= '0;
			pend_q       <= 1'b0;
			pend_addr_q  <= '0;
			count_q      <= '0;
			res_status_q <= ST_OK;
			res_found_q  <= '0;
			hit_q        <= 1'b0;
			out_valid_q  <= 1'b0;
			out_status_q <= '0;
			out_found_q  <= '0;
			out_total_q  <= '0;
		end else begin
			// in the finish step the output register is reloaded instead
			if (out_valid_q && out_ready && state_q != S_FIN) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						op_q         <= ale_op_t'(operation);
						value_q      <= value;
						pend_q       <= 1'b0;
						hit_q        <= 1'b0;
						res_found_q  <= '0;
						res_status_q <= ST_OK;
						case (ale_op_t'(operation))
							OP_INS_POS: begin
								if (full) begin
									res_status_q <= ST_FULL;
									state_q      <= S_FIN;
								end else if (pos_in > count_q) begin
									res_status_q <= ST_BADPOS;
									state_q      <= S_FIN;
								end else begin
									pos_q    <= pos_in;
									cursor_q <= count_q;
									state_q  <= S_SHUP;
								end
							end
							OP_INS_SORT: begin
								if (full) begin
									res_status_q <= ST_FULL;
									state_q      <= S_FIN;
								end else begin
									cursor_q <= '0;
									state_q  <= S_SCAN;
								end
							end
							OP_DELETE: begin
								if (pos_in >= count_q) begin
									res_status_q <= ST_BADPOS;
									state_q      <= S_FIN;
								end else begin
									cursor_q <= pos_in;
									state_q  <= S_SHDN;
								end
							end
							default: begin
								cursor_q <= '0;
								state_q  <= S_SCAN;
							end
						endcase
					end
				end
				S_SCAN: begin
					if (less_now) begin
						// first strictly greater entry found: insert in front of it
						pos_q    <= CNT_W'(pend_addr_q);
						cursor_q <= count_q;
						pend_q   <= 1'b0;
						state_q  <= S_SHUP;
					end else begin
						if (match_now) begin
							hit_q       <= 1'b1;
							res_found_q <= pend_addr_q;
						end
						if (cursor_q < count_q) begin
							pend_q      <= 1'b1;
							pend_addr_q <= cursor_q[ADDR_W-1:0];
							cursor_q    <= cur_inc;
						end else begin
							pend_q <= 1'b0;
							if (!pend_q) begin
								if (op_q == OP_INS_SORT) begin
									pos_q    <= count_q;
									cursor_q <= count_q;
									state_q  <= S_SHUP;
								end else begin
									res_status_q <= hit_q ? ST_OK : ST_MISSING;
									state_q      <= S_FIN;
								end
							end
						end
					end
				end
				S_SHUP: begin
					if (cursor_q > pos_q) begin
						pend_q      <= 1'b1;
						pend_addr_q <= cursor_q[ADDR_W-1:0];
						cursor_q    <= cur_dec;
					end else begin
						pend_q  <= 1'b0;
						state_q <= S_PUT;
					end
				end
				S_PUT: begin
					count_q <= count_q + CNT_W'(1);
					state_q <= S_FIN;
				end
				S_SHDN: begin
					if (cur_inc < count_q) begin
						pend_q      <= 1'b1;
						pend_addr_q <= cursor_q[ADDR_W-1:0];
						cursor_q    <= cur_inc;
					end else begin
						pend_q  <= 1'b0;
						count_q <= count_q - CNT_W'(1);
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q  <= 1'b1;
						out_status_q <= res_status_q;
						out_found_q  <= 4'(res_found_q);
						out_total_q  <= 5'(count_q);
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready      = (state_q == S_IDLE);
	assign out_valid     = out_valid_q;
	assign status        = out_status_q;
	assign found_index   = out_found_q;
	assign element_total = out_total_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("element count above capacity");

	a_write_state: assert property (@(posedge clk) disable iff (!arst_n)
		wr.we |-> (state_q == S_SHUP || state_q == S_SHDN || state_q == S_PUT))
		else $error("store written outside a shift or put step");

	a_full_total: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_status_q == ST_FULL) |-> (out_total_q == 5'(CAPACITY)))
		else $error("full status with list not at capacity");

	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_found_q != 4'd0) |-> (out_status_q == ST_OK))
		else $error("nonzero found index on a failed request");

	a_count_move: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PUT) |=> (count_q == $past(count_q) + CNT_W'(1)))
		else $error("insert did not grow the list");
`endif

endmodule

// ===== hdl/ale_store.sv =====
// entry storage for the array list engine: one write port, one registered read port
// depends on ale_pkg
module ale_store (
	input  logic                          clk,
	input  ale_pkg::ale_wr_t              wr,
	input  logic [ale_pkg::ADDR_W-1:0]    rd_addr,
	output logic [ale_pkg::DATA_W-1:0]    rd_data
);
	import ale_pkg::*;

	logic [DATA_W-1:0] mem [CAPACITY];
	logic [DATA_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem[wr.addr] <= wr.data;
		end
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule
